>>> sv/mau_pkg.sv
// Package for the multiprecision arithmetic unit: sizes, item codes and the
// request/response types of the shared adder. No dependencies.
package mau_pkg;

	localparam int WORD_COUNT = 8;
	localparam int WORD_W     = 32;
	localparam int BITS       = WORD_COUNT * WORD_W;
	localparam int IDX_W      = 6;
	localparam int WSEL_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CNT_W      = $clog2(BITS);
	localparam int EBIT_W     = 5;
	localparam int OPC_W      = 3;
	localparam logic [31:0] EXP_RESET = 32'd65537;

	localparam logic [1:0] ACT_WR_A  = 2'd0;
	localparam logic [1:0] ACT_WR_B  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [OPC_W-1:0] OP_ADD = 3'd0;
	localparam logic [OPC_W-1:0] OP_SUB = 3'd1;
	localparam logic [OPC_W-1:0] OP_MUL = 3'd2;
	localparam logic [OPC_W-1:0] OP_DIV = 3'd3;
	localparam logic [OPC_W-1:0] OP_MOD = 3'd4;
	localparam logic [OPC_W-1:0] OP_POW = 3'd5;

	typedef struct packed {
		logic [BITS:0] x;
		logic [BITS:0] y;
		logic          sub;
	} alu_req_t;

	typedef struct packed {
		logic [BITS:0] sum;
		logic          cout;
	} alu_rsp_t;

endpackage

>>> sv/mau_alu.sv
// Shared wide adder/subtractor of the arithmetic unit.
// Depends on mau_pkg for widths and the request/response structs.
module mau_alu (
	input  mau_pkg::alu_req_t req,
	output mau_pkg::alu_rsp_t rsp
);
	import mau_pkg::*;

	logic [BITS+1:0] s;

	// x - y as x + ~y + 1; cout set means no borrow
	assign s = {1'b0, req.x} + {1'b0, (req.sub ? ~req.y : req.y)} + (BITS+2)'(req.sub);
	assign rsp.sum  = s[BITS:0];
	assign rsp.cout = s[BITS+1];

endmodule

>>> sv/multiprecision_arithmetic_unit.sv
// Top level of the multiprecision arithmetic unit: operand/result registers,
// sequencer and stream ports. Depends on mau_pkg and mau_alu.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | s_tvalid/tready  | tuser: action; tdata: index, value, opcode
//  m_*     | out | m_tvalid/tready  | tdata: read_value, carry_flag, status
//  cfg_*   | in  | cfg_we           | cfg_wdata: exponent
//
// Loads, reads, add, sub, unknown opcodes and zero-divisor starts post their item
// the cycle after accept.
// Mul and div/mod: one bit per cycle through the shared adder, then the result is posted.
// Power: reduce A mod B, then per exponent bit 1 or 2 modular multiplies, each a setup
// state and three adder passes per bit of the multiplier; then the result is posted.
// Reset clears all state; the exponent resets to 65537.
// No item is taken while an operation runs or a result waits to be taken.
module multiprecision_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // word_index[5:0], word_value[37:6], opcode[40:38]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], carry_flag[32], status[33]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import mau_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIV, S_PSTART, S_MM0, S_MM1, S_MM2, S_RESP
	} state_t;

	state_t             state_q;
	logic [BITS-1:0]    a_q, b_q, r_q, w_q, y_q, base_q;
	logic [BITS:0]      m_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EBIT_W-1:0]  ebit_q;
	logic               sq_q;
	logic [OPC_W-1:0]   op_q;
	logic [31:0]        exp_q;
	logic               carry_q, status_q, out_v_q;
	logic [WORD_W-1:0]  rd_q;

	alu_req_t           req;
	alu_rsp_t           rsp;

	logic [IDX_W-1:0]   idx;
	logic [WSEL_W-1:0]  wsel;
	logic [WORD_W-1:0]  val;
	logic [OPC_W-1:0]   opc;
	logic               idx_ok, accept, out_free, last_bit, b_zero;
	logic [BITS:0]      shl;

	assign idx    = s_tdata[5:0];
	assign val    = s_tdata[37:6];
	assign opc    = s_tdata[40:38];
	assign wsel   = idx[WSEL_W-1:0];
	assign idx_ok = {1'b0, idx} < (IDX_W+1)'(WORD_COUNT);
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign last_bit = cnt_q == CNT_W'(BITS - 1);
	assign b_zero   = b_q == '0;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, status_q, carry_q, rd_q};

	// div shifts the next numerator bit in; MM0 doubles the accumulator
	assign shl = (state_q == S_DIV) ? {m_q[BITS-1:0], w_q[BITS-1]} : {m_q[BITS-1:0], 1'b0};

	always_comb begin
		req.x   = {1'b0, a_q};
		req.y   = {1'b0, b_q};
		req.sub = opc == OP_SUB;
		unique case (state_q)
			S_MUL: begin
				req.x   = {1'b0, m_q[BITS-2:0], 1'b0};
				req.y   = w_q[BITS-1] ? {1'b0, b_q} : '0;
				req.sub = 1'b0;
			end
			S_DIV, S_MM0: begin
				req.x   = shl;
				req.sub = 1'b1;
			end
			S_MM1: begin
				req.x   = m_q;
				req.y   = w_q[BITS-1] ? {1'b0, y_q} : '0;
				req.sub = 1'b0;
			end
			S_MM2: begin
				req.x   = m_q;
				req.sub = 1'b1;
			end
			default: ;
		endcase
	end

	mau_alu u_alu (
		.req (req),
		.rsp (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			a_q      <= '0;
			b_q      <= '0;
			r_q      <= '0;
			w_q      <= '0;
			y_q      <= '0;
			base_q   <= '0;
			m_q      <= '0;
			exp_q    <= EXP_RESET;
			carry_q  <= 1'b0;
			status_q <= 1'b0;
			out_v_q  <= 1'b0;
			rd_q     <= '0;
			cnt_q    <= '0;
			ebit_q   <= '0;
			sq_q     <= 1'b0;
			op_q     <= OP_ADD;
		end else begin
			if (cfg_we)
				exp_q <= cfg_wdata;
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_v_q <= 1'b1;
						rd_q    <= '0;
						op_q    <= opc;
						unique case (s_tuser)
							ACT_WR_A: if (idx_ok) a_q[wsel*WORD_W +: WORD_W] <= val;
							ACT_WR_B: if (idx_ok) b_q[wsel*WORD_W +: WORD_W] <= val;
							ACT_READ: if (idx_ok) rd_q <= r_q[wsel*WORD_W +: WORD_W];
							ACT_START: begin
								case (opc)
									OP_ADD: begin
										r_q      <= rsp.sum[BITS-1:0];
										carry_q  <= rsp.sum[BITS];
										status_q <= 1'b0;
									end
									OP_SUB: begin
										r_q      <= rsp.sum[BITS-1:0];
										carry_q  <= !rsp.cout;
										status_q <= 1'b0;
									end
									OP_MUL: begin
										carry_q  <= 1'b0;
										status_q <= 1'b0;
										out_v_q  <= 1'b0;
										w_q      <= a_q;
										m_q      <= '0;
										cnt_q    <= '0;
										state_q  <= S_MUL;
									end
									OP_DIV, OP_MOD, OP_POW: begin
										carry_q <= 1'b0;
										if (b_zero) begin
											r_q      <= '1;
											status_q <= 1'b1;
										end else begin
											status_q <= 1'b0;
											out_v_q  <= 1'b0;
											w_q      <= a_q;
											m_q      <= '0;
											cnt_q    <= '0;
											state_q  <= S_DIV;
										end
									end
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					m_q   <= {1'b0, rsp.sum[BITS-1:0]};
					w_q   <= {w_q[BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						r_q     <= rsp.sum[BITS-1:0];
						state_q <= S_RESP;
					end
				end
				S_DIV: begin
					m_q   <= rsp.cout ? rsp.sum : shl;
					w_q   <= {w_q[BITS-2:0], rsp.cout};
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						if (op_q == OP_DIV) begin
							r_q     <= {w_q[BITS-2:0], rsp.cout};
							state_q <= S_RESP;
						end else if (op_q == OP_MOD) begin
							r_q     <= rsp.cout ? rsp.sum[BITS-1:0] : shl[BITS-1:0];
							state_q <= S_RESP;
						end else begin
							// base = A mod B, accumulator = 1 mod B
							base_q  <= rsp.cout ? rsp.sum[BITS-1:0] : shl[BITS-1:0];
							m_q     <= (BITS+1)'(b_q != BITS'(1));
							ebit_q  <= '1;
							sq_q    <= 1'b1;
							state_q <= S_PSTART;
						end
					end
				end
				S_PSTART: begin
					w_q     <= m_q[BITS-1:0];
					y_q     <= sq_q ? m_q[BITS-1:0] : base_q;
					m_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_MM0;
				end
				S_MM0: begin
					m_q     <= rsp.cout ? rsp.sum : shl;
					state_q <= S_MM1;
				end
				S_MM1: begin
					m_q     <= rsp.sum;
					w_q     <= {w_q[BITS-2:0], 1'b0};
					state_q <= S_MM2;
				end
				S_MM2: begin
					if (rsp.cout)
						m_q <= rsp.sum;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_MM0;
					if (last_bit) begin
						state_q <= S_PSTART;
						if (sq_q && exp_q[ebit_q]) begin
							sq_q <= 1'b0;
						end else if (ebit_q == '0) begin
							r_q     <= rsp.cout ? rsp.sum[BITS-1:0] : m_q[BITS-1:0];
							state_q <= S_RESP;
						end else begin
							sq_q   <= 1'b1;
							ebit_q <= ebit_q - 1'b1;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						rd_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input only taken while the sequencer is parked
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("input ready while sequencer busy");

	// a zero-divisor status always goes with an all-ones result
	a_status_ones: assert property (@(posedge clk) disable iff (!arst_n)
		status_q |-> r_q == '1)
		else $error("status set without all-ones result");

	// modular multiply keeps its accumulator reduced at each bit boundary
	a_mm_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MM0 |-> m_q < {1'b0, b_q})
		else $error("modular accumulator not reduced");

	// a result is never offered while a multiply, divide or MM0 step runs
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV || state_q == S_MM0) |-> !$rose(out_v_q))
		else $error("result raised during operation");

endmodule
